>>> design/pal_pkg.sv
package pal_pkg;

	// store size and widths
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = 6;

	// request kinds
	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOCATE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// request word
	typedef struct packed {
		logic [1:0]        kind;
		logic [5:0]        position;
		logic signed [31:0] value;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [5:0]         found_position;
		logic [5:0]         count;
	} out_word_t;

	// per-cell control word
	typedef struct packed {
		logic take_left;
		logic take_right;
		logic load_new;
		logic check;
	} cell_ctrl_t;

endpackage

>>> design/positional_array_list_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell. A request word is taken when start is high and busy is
// low; its result word appears on result for exactly one cycle with done high,
// after the request has passed through the EXEC and FIND states. There is no
// back-pressure: the receiver must take the result in the cycle that done is
// high. Busy is high in EXEC and FIND, so no new request is taken while one is
// in progress, and a new one can be accepted in the cycle that the previous
// result is shown. EXEC runs the shift-and-compare step in the cells and FIND
// the first-match priority encoder over the registered match flags. The store
// and length are cleared by reset with no clearing pass.
module positional_array_list_top import pal_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  req,
	output logic      done,
	output out_word_t result
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FIND = 3'b100
	} state_t;

	state_t     state_q;
	in_word_t   req_q;
	logic [LEN_W-1:0] len_q;
	out_word_t  res_q;
	logic       done_q;

	logic [31:0]        entry_w [CAPACITY];
	logic [CAPACITY-1:0] match_w;
	cell_ctrl_t         ctrl_w [CAPACITY];

	logic [LEN_W-1:0] p_w;
	logic             is_ins, is_del, is_loc;
	logic             ins_bad, ins_full, ins_ok, del_ok;
	logic [CAPACITY-1:0] sel_w;
	logic [31:0]      rem_w;
	logic [IDX_W-1:0] first_idx;
	logic             any_match;

	// request decode
	assign is_ins = (state_q == S_EXEC) && (req_q.kind == KIND_INSERT);
	assign is_del = (state_q == S_EXEC) && (req_q.kind == KIND_DELETE);
	assign is_loc = (state_q == S_EXEC) && (req_q.kind == KIND_LOCATE);
	assign p_w    = req_q.position - LEN_W'(1);

	assign ins_bad  = (req_q.position == '0) ||
		({1'b0, req_q.position} > ({1'b0, len_q} + (LEN_W+1)'(1)));
	assign ins_full = (len_q == LEN_W'(CAPACITY));
	assign ins_ok   = is_ins && !ins_bad && !ins_full;
	assign del_ok   = is_del && (req_q.position != '0) && (req_q.position <= len_q);

	// per-cell controls and the row of cells
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [31:0] left_w, right_w;

			assign ctrl_w[gi].take_left  = ins_ok && (LEN_W'(gi) > p_w);
			assign ctrl_w[gi].load_new   = ins_ok && (LEN_W'(gi) == p_w);
			assign ctrl_w[gi].take_right = del_ok && (LEN_W'(gi) >= p_w);
			assign ctrl_w[gi].check      = is_loc && (LEN_W'(gi) < len_q);
			assign sel_w[gi]             = (LEN_W'(gi) == p_w);

			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = entry_w[gi-1];
			end
			if (gi == CAPACITY-1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = entry_w[gi+1];
			end

			pal_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl_w[gi]),
				.left   (left_w),
				.right  (right_w),
				.key    (req_q.value),
				.entry  (entry_w[gi]),
				.match  (match_w[gi])
			);
		end
	endgenerate

	// removed entry: and-or select of the addressed cell
	always_comb begin
		rem_w = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rem_w = rem_w | (sel_w[i] ? entry_w[i] : 32'd0);
		end
	end

	// first match among the registered flags
	always_comb begin
		first_idx = '0;
		any_match = |match_w;
		for (int i = CAPACITY-1; i >= 0; i--) begin
			if (match_w[i]) begin
				first_idx = IDX_W'(i);
			end
		end
	end

	// control sequencer, length and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ins_ok) begin
						len_q <= len_q + LEN_W'(1);
					end else if (del_ok) begin
						len_q <= len_q - LEN_W'(1);
					end
					state_q <= S_FIND;
				end
				S_FIND: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_EXEC) begin
			res_q.status         <= ST_OK;
			res_q.removed_value  <= '0;
			res_q.found_position <= '0;
			if (is_ins && ins_bad) begin
				res_q.status <= ST_BADPOS;
			end else if (is_ins && ins_full) begin
				res_q.status <= ST_FULL;
			end else if (is_del && !del_ok) begin
				res_q.status <= ST_BADPOS;
			end else if (del_ok) begin
				res_q.removed_value <= rem_w;
			end
		end
		if (state_q == S_FIND) begin
			res_q.count <= len_q;
			if (req_q.kind == KIND_LOCATE) begin
				if (any_match) begin
					res_q.found_position <= LEN_W'(first_idx) + LEN_W'(1);
				end else begin
					res_q.status <= ST_NOTFOUND;
				end
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length above capacity");

	a_done_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIND))
		else $error("result strobe without search step");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.count == LEN_W'(CAPACITY)))
		else $error("full status with room left");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found_position != '0) |-> (result.status == ST_OK))
		else $error("found position with failing status");

endmodule

>>> design/pal_cell.sv
module pal_cell import pal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctrl_t  ctrl,
	input  logic [31:0] left,
	input  logic [31:0] right,
	input  logic [31:0] key,
	output logic [31:0] entry,
	output logic        match
);

	logic [31:0] entry_q;
	logic        match_q;

	// entry register: shift up, shift down or take the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.take_left) begin
			entry_q <= left;
		end else if (ctrl.take_right) begin
			entry_q <= right;
		end else if (ctrl.load_new) begin
			entry_q <= key;
		end
	end

	// registered compare against the search key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctrl.check && (entry_q == key);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule
